@@ hdl/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared widths and controller/datapath interface types for the LFU cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

    localparam int COUNT_BITS = 32;
    localparam int STAMP_BITS = 40;
    localparam int CAP_BITS   = 8;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 8'd100;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

@@ hdl/lfu_ram.sv @@
// ----------------------------------------------------------------------------
// lfu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hdl/lfu_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: accept an item, sweep the table, commit the update and result.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire lfu_pkg::t_dp_status i_status,
    output lfu_pkg::t_ctrl_cmd      o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_UPD  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_cmd.start   = (r_state == ST_IDLE) && i_valid;
    assign o_cmd.scan    = (r_state == ST_SCAN);
    assign o_cmd.commit  = (r_state == ST_UPD) && i_status.out_free;

endmodule

`default_nettype wire

@@ hdl/lfu_dp.sv @@
// ----------------------------------------------------------------------------
// lfu_dp
// Datapath: entry table, sweep trackers for match/victim/free slot, update
// logic, capacity register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_dp #(
    parameter int ENTRIES  = 128,
    parameter int KEY_BITS = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire lfu_pkg::t_ctrl_cmd                 i_cmd,
    output lfu_pkg::t_dp_status                     o_status,
    input  wire logic                               i_command,
    input  wire logic [KEY_BITS-1:0]                i_key,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [lfu_pkg::CAP_BITS-1:0]       i_cfg_wr_data,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic                                    o_hit,
    output logic [lfu_pkg::COUNT_BITS-1:0]          o_use_count,
    output logic                                    o_evicted,
    output logic [KEY_BITS-1:0]                     o_evicted_key
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > lfu_pkg::CAP_BITS) ? CNT_W : lfu_pkg::CAP_BITS;
    localparam int CB     = lfu_pkg::COUNT_BITS;
    localparam int SB     = lfu_pkg::STAMP_BITS;
    localparam int DATA_W = KEY_BITS + CB + SB;

    logic                       r_cmd;
    logic [KEY_BITS-1:0]        r_key;
    logic [CNT_W-1:0]           r_idx;
    logic                       r_pv;
    logic [IDX_W-1:0]           r_pidx;
    logic                       r_found;
    logic [IDX_W-1:0]           r_mslot;
    logic [CB-1:0]              r_mcount;
    logic                       r_have_v;
    logic [IDX_W-1:0]           r_vslot;
    logic [KEY_BITS-1:0]        r_vkey;
    logic [CB-1:0]              r_vcount;
    logic [SB-1:0]              r_vstamp;
    logic                       r_have_free;
    logic [IDX_W-1:0]           r_fslot;
    logic [ENTRIES-1:0]         r_valid;
    logic [ENTRIES-1:0]         n_valid;
    logic [CNT_W-1:0]           r_occ;
    logic [SB-1:0]              r_stamp;
    logic [lfu_pkg::CAP_BITS-1:0] r_capacity;
    logic                       r_out_valid;

    logic [DATA_W-1:0]          rd_data;
    logic [KEY_BITS-1:0]        rd_key;
    logic [CB-1:0]              rd_count;
    logic [SB-1:0]              rd_stamp;
    logic                       rd_vld;

    logic [CMP_W-1:0]           cap_ext;
    logic [CMP_W-1:0]           cap_sat;
    logic                       use_en;
    logic                       evict;
    logic [CB-1:0]              inc_count;
    logic [IDX_W-1:0]           ins_slot;
    logic [IDX_W-1:0]           wr_slot;
    logic [DATA_W-1:0]          wr_data;
    logic                       wr_en;
    logic [CB-1:0]              res_count;

    lfu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_slot),
        .i_wdata (wr_data),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    assign rd_key   = rd_data[DATA_W-1 -: KEY_BITS];
    assign rd_count = rd_data[SB +: CB];
    assign rd_stamp = rd_data[SB-1:0];
    assign rd_vld   = r_valid[r_pidx];

    assign cap_ext   = CMP_W'(r_capacity);
    assign cap_sat   = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
    assign use_en    = r_cmd && (cap_sat != '0);
    assign evict     = use_en && !r_found && (CMP_W'(r_occ) >= cap_sat) && r_have_v;
    assign inc_count = (r_mcount == '1) ? r_mcount : r_mcount + 1'b1;

    always_comb begin
        ins_slot = r_fslot;
        if (evict && (!r_have_free || (r_vslot < r_fslot))) begin
            ins_slot = r_vslot;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (evict) begin
            n_valid[r_vslot] = 1'b0;
        end
        n_valid[ins_slot] = 1'b1;
    end

    always_comb begin
        wr_en   = i_cmd.commit && use_en;
        wr_slot = r_found ? r_mslot : ins_slot;
        wr_data = r_found ? {r_key, inc_count, r_stamp} : {r_key, CB'(1), r_stamp};
        if (r_found) begin
            res_count = use_en ? inc_count : r_mcount;
        end else begin
            res_count = use_en ? CB'(1) : '0;
        end
    end

    assign o_status.scan_done = (r_idx == CNT_W'(ENTRIES)) && !r_pv;
    assign o_status.out_free  = !r_out_valid || i_ready;
    assign o_valid            = r_out_valid;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_pv        <= 1'b0;
            r_found     <= 1'b0;
            r_have_v    <= 1'b0;
            r_have_free <= 1'b0;
            r_valid     <= '0;
            r_occ       <= '0;
            r_stamp     <= '0;
            r_capacity  <= lfu_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (i_cmd.start) begin
                r_idx       <= '0;
                r_pv        <= 1'b0;
                r_found     <= 1'b0;
                r_have_v    <= 1'b0;
                r_have_free <= 1'b0;
            end
            if (i_cmd.scan) begin
                if (r_idx != CNT_W'(ENTRIES)) begin
                    r_idx <= r_idx + 1'b1;
                end
                r_pv <= (r_idx != CNT_W'(ENTRIES));
                if (r_pv) begin
                    if (rd_vld && !r_found && (rd_key == r_key)) begin
                        r_found <= 1'b1;
                    end
                    if (rd_vld && (!r_have_v || ({rd_count, rd_stamp} < {r_vcount, r_vstamp})))
                    begin
                        r_have_v <= 1'b1;
                    end
                    if (!rd_vld) begin
                        r_have_free <= 1'b1;
                    end
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (use_en) begin
                    r_stamp <= r_stamp + 1'b1;
                    if (!r_found) begin
                        r_valid <= n_valid;
                        if (!evict) begin
                            r_occ <= r_occ + 1'b1;
                        end
                    end
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cmd <= i_command;
            r_key <= i_key;
        end
        if (i_cmd.scan) begin
            r_pidx <= r_idx[IDX_W-1:0];
            if (r_pv) begin
                if (rd_vld && !r_found && (rd_key == r_key)) begin
                    r_mslot  <= r_pidx;
                    r_mcount <= rd_count;
                end
                if (rd_vld && (!r_have_v || ({rd_count, rd_stamp} < {r_vcount, r_vstamp}))) begin
                    r_vslot  <= r_pidx;
                    r_vkey   <= rd_key;
                    r_vcount <= rd_count;
                    r_vstamp <= rd_stamp;
                end
                if (!rd_vld && !r_have_free) begin
                    r_fslot <= r_pidx;
                end
            end
        end
        if (i_cmd.commit) begin
            o_hit         <= r_found;
            o_use_count   <= res_count;
            o_evicted     <= evict;
            o_evicted_key <= evict ? r_vkey : '0;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lfu_frequency_cache_unit.sv @@
// ----------------------------------------------------------------------------
// lfu_frequency_cache_unit
// Least-frequently-used key cache with oldest-stamp tie break.
// ----------------------------------------------------------------------------
// Flow: one item at a time; a new item is accepted only once the previous
//   result is committed, after a one-slot-per-cycle sweep over the entry table
//   RAM read port; a stalled result holds the update.
// Reset: synchronous, active low; clears valid bits, occupancy, stamp counter
//   and output valid; capacity returns to 100. No clearing pass is needed.
`default_nettype none

module lfu_frequency_cache_unit #(
    parameter int ENTRIES  = 128,
    parameter int KEY_BITS = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic                               i_command,
    input  wire logic [KEY_BITS-1:0]                i_key,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [lfu_pkg::CAP_BITS-1:0]       i_cfg_wr_data,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic                                    o_hit,
    output logic [lfu_pkg::COUNT_BITS-1:0]          o_use_count,
    output logic                                    o_evicted,
    output logic [KEY_BITS-1:0]                     o_evicted_key
);

    lfu_pkg::t_ctrl_cmd  cmd;
    lfu_pkg::t_dp_status status;

    lfu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    lfu_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hit         (o_hit),
        .o_use_count   (o_use_count),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

endmodule

`default_nettype wire
